// ===== rtl/core/csbd_pkg.sv =====
// ----------------------------------------------------------------------------
// csbd_pkg
// shared types, constants and the voltage-to-soc rom for the balance unit
// ----------------------------------------------------------------------------
`default_nettype none
package csbd_pkg;

    localparam int NUM_CELLS    = 4;
    localparam int TABLE_POINTS = 142;
    localparam int VOLT_W       = 16;
    localparam int SOC_W        = 14;
    localparam int CELL_W       = $clog2(NUM_CELLS);
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;

    typedef logic [VOLT_W-1:0] t_volt;
    typedef logic [SOC_W-1:0]  t_soc;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CELL_W-1:0] t_cell;

    // classified lookup job handed from the front end to the back end
    typedef struct packed {
        logic  clamp;   // result is rom soc at idx, no interpolation
        t_idx  idx;     // upper point for interpolation, or clamp point
        t_volt volt;
        t_cell cell_no;
    } t_job;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_SEARCH,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_MUL,
        BE_DIV,
        BE_DONE
    } t_be_state;

    function automatic t_volt rom_volt(input t_idx i);
        t_volt v;
        case (i)
            8'd0: v = 16'd25210;   8'd1: v = 16'd25330;   8'd2: v = 16'd26220;
            8'd3: v = 16'd26430;   8'd4: v = 16'd26560;   8'd5: v = 16'd26720;
            8'd6: v = 16'd26890;   8'd7: v = 16'd27230;   8'd8: v = 16'd27570;
            8'd9: v = 16'd27910;   8'd10: v = 16'd28120;  8'd11: v = 16'd28410;
            8'd12: v = 16'd28750;  8'd13: v = 16'd29090;  8'd14: v = 16'd29340;
            8'd15: v = 16'd29680;  8'd16: v = 16'd30010;  8'd17: v = 16'd30350;
            8'd18: v = 16'd30600;  8'd19: v = 16'd30900;  8'd20: v = 16'd31150;
            8'd21: v = 16'd31450;  8'd22: v = 16'd31660;  8'd23: v = 16'd31870;
            8'd24: v = 16'd32040;  8'd25: v = 16'd32290;  8'd26: v = 16'd32500;
            8'd27: v = 16'd32670;  8'd28: v = 16'd32840;  8'd29: v = 16'd33010;
            8'd30: v = 16'd33130;  8'd31: v = 16'd33260;  8'd32: v = 16'd33390;
            8'd33: v = 16'd33470;  8'd34: v = 16'd33550;  8'd35: v = 16'd33640;
            8'd36: v = 16'd33760;  8'd37: v = 16'd33850;  8'd38: v = 16'd33930;
            8'd39: v = 16'd34020;  8'd40: v = 16'd34100;  8'd41: v = 16'd34190;
            8'd42: v = 16'd34230;  8'd43: v = 16'd34310;  8'd44: v = 16'd34400;
            8'd45: v = 16'd34440;  8'd46: v = 16'd34480;  8'd47: v = 16'd34560;
            8'd48: v = 16'd34610;  8'd49: v = 16'd34690;  8'd50: v = 16'd34730;
            8'd51: v = 16'd34810;  8'd52: v = 16'd34900;  8'd53: v = 16'd34940;
            8'd54: v = 16'd34980;  8'd55: v = 16'd35020;  8'd56: v = 16'd35070;
            8'd57: v = 16'd35110;  8'd58: v = 16'd35150;  8'd59: v = 16'd35190;
            8'd60: v = 16'd35230;  8'd61: v = 16'd35280;  8'd62: v = 16'd35360;
            8'd63: v = 16'd35400;  8'd64: v = 16'd35440;  8'd65: v = 16'd35490;
            8'd66: v = 16'd35530;  8'd67: v = 16'd35570;  8'd68: v = 16'd35610;
            8'd69: v = 16'd35650;  8'd70: v = 16'd35700;  8'd71: v = 16'd35780;
            8'd72: v = 16'd35820;  8'd73: v = 16'd35910;  8'd74: v = 16'd35950;
            8'd75: v = 16'd35990;  8'd76: v = 16'd36070;  8'd77: v = 16'd36120;
            8'd78: v = 16'd36200;  8'd79: v = 16'd36240;  8'd80: v = 16'd36330;
            8'd81: v = 16'd36410;  8'd82: v = 16'd36450;  8'd83: v = 16'd36540;
            8'd84: v = 16'd36620;  8'd85: v = 16'd36700;  8'd86: v = 16'd36790;
            8'd87: v = 16'd36830;  8'd88: v = 16'd36870;  8'd89: v = 16'd36960;
            8'd90: v = 16'd37000;  8'd91: v = 16'd37080;  8'd92: v = 16'd37170;
            8'd93: v = 16'd37210;  8'd94: v = 16'd37290;  8'd95: v = 16'd37380;
            8'd96: v = 16'd37420;  8'd97: v = 16'd37500;  8'd98: v = 16'd37590;
            8'd99: v = 16'd37630;  8'd100: v = 16'd37710; 8'd101: v = 16'd37750;
            8'd102: v = 16'd37840; 8'd103: v = 16'd37880; 8'd104: v = 16'd37960;
            8'd105: v = 16'd38050; 8'd106: v = 16'd38130; 8'd107: v = 16'd38170;
            8'd108: v = 16'd38260; 8'd109: v = 16'd38340; 8'd110: v = 16'd38430;
            8'd111: v = 16'd38470; 8'd112: v = 16'd38550; 8'd113: v = 16'd38680;
            8'd114: v = 16'd38760; 8'd115: v = 16'd38850; 8'd116: v = 16'd38930;
            8'd117: v = 16'd39060; 8'd118: v = 16'd39140; 8'd119: v = 16'd39270;
            8'd120: v = 16'd39350; 8'd121: v = 16'd39440; 8'd122: v = 16'd39520;
            8'd123: v = 16'd39600; 8'd124: v = 16'd39730; 8'd125: v = 16'd39810;
            8'd126: v = 16'd39940; 8'd127: v = 16'd40020; 8'd128: v = 16'd40070;
            8'd129: v = 16'd40190; 8'd130: v = 16'd40280; 8'd131: v = 16'd40360;
            8'd132: v = 16'd40450; 8'd133: v = 16'd40530; 8'd134: v = 16'd40610;
            8'd135: v = 16'd40660; 8'd136: v = 16'd40700; 8'd137: v = 16'd40780;
            8'd138: v = 16'd40820; 8'd139: v = 16'd40990; 8'd140: v = 16'd41160;
            8'd141: v = 16'd41290;
            default: v = 16'd41290;
        endcase
        return v;
    endfunction

    function automatic t_soc rom_soc(input t_idx i);
        t_soc s;
        case (i)
            8'd0: s = 14'd56;     8'd1: s = 14'd89;     8'd2: s = 14'd121;
            8'd3: s = 14'd131;    8'd4: s = 14'd154;    8'd5: s = 14'd156;
            8'd6: s = 14'd161;    8'd7: s = 14'd186;    8'd8: s = 14'd196;
            8'd9: s = 14'd219;    8'd10: s = 14'd251;   8'd11: s = 14'd261;
            8'd12: s = 14'd284;   8'd13: s = 14'd317;   8'd14: s = 14'd349;
            8'd15: s = 14'd382;   8'd16: s = 14'd447;   8'd17: s = 14'd479;
            8'd18: s = 14'd512;   8'd19: s = 14'd577;   8'd20: s = 14'd610;
            8'd21: s = 14'd707;   8'd22: s = 14'd740;   8'd23: s = 14'd805;
            8'd24: s = 14'd870;   8'd25: s = 14'd935;   8'd26: s = 14'd1033;
            8'd27: s = 14'd1131;  8'd28: s = 14'd1196;  8'd29: s = 14'd1294;
            8'd30: s = 14'd1392;  8'd31: s = 14'd1457;  8'd32: s = 14'd1554;
            8'd33: s = 14'd1620;  8'd34: s = 14'd1685;  8'd35: s = 14'd1782;
            8'd36: s = 14'd1848;  8'd37: s = 14'd1945;  8'd38: s = 14'd2010;
            8'd39: s = 14'd2108;  8'd40: s = 14'd2173;  8'd41: s = 14'd2238;
            8'd42: s = 14'd2336;  8'd43: s = 14'd2434;  8'd44: s = 14'd2499;
            8'd45: s = 14'd2597;  8'd46: s = 14'd2629;  8'd47: s = 14'd2727;
            8'd48: s = 14'd2760;  8'd49: s = 14'd2857;  8'd50: s = 14'd2955;
            8'd51: s = 14'd3053;  8'd52: s = 14'd3150;  8'd53: s = 14'd3248;
            8'd54: s = 14'd3313;  8'd55: s = 14'd3346;  8'd56: s = 14'd3444;
            8'd57: s = 14'd3509;  8'd58: s = 14'd3574;  8'd59: s = 14'd3672;
            8'd60: s = 14'd3704;  8'd61: s = 14'd3769;  8'd62: s = 14'd3900;
            8'd63: s = 14'd3965;  8'd64: s = 14'd4030;  8'd65: s = 14'd4095;
            8'd66: s = 14'd4193;  8'd67: s = 14'd4258;  8'd68: s = 14'd4323;
            8'd69: s = 14'd4388;  8'd70: s = 14'd4453;  8'd71: s = 14'd4551;
            8'd72: s = 14'd4649;  8'd73: s = 14'd4714;  8'd74: s = 14'd4812;
            8'd75: s = 14'd4877;  8'd76: s = 14'd4975;  8'd77: s = 14'd5072;
            8'd78: s = 14'd5137;  8'd79: s = 14'd5235;  8'd80: s = 14'd5300;
            8'd81: s = 14'd5398;  8'd82: s = 14'd5463;  8'd83: s = 14'd5561;
            8'd84: s = 14'd5659;  8'd85: s = 14'd5724;  8'd86: s = 14'd5821;
            8'd87: s = 14'd5854;  8'd88: s = 14'd5952;  8'd89: s = 14'd6017;
            8'd90: s = 14'd6049;  8'd91: s = 14'd6147;  8'd92: s = 14'd6212;
            8'd93: s = 14'd6277;  8'd94: s = 14'd6343;  8'd95: s = 14'd6440;
            8'd96: s = 14'd6538;  8'd97: s = 14'd6603;  8'd98: s = 14'd6668;
            8'd99: s = 14'd6734;  8'd100: s = 14'd6815; 8'd101: s = 14'd6883;
            8'd102: s = 14'd6965; 8'd103: s = 14'd7023; 8'd104: s = 14'd7118;
            8'd105: s = 14'd7199; 8'd106: s = 14'd7294; 8'd107: s = 14'd7365;
            8'd108: s = 14'd7434; 8'd109: s = 14'd7506; 8'd110: s = 14'd7597;
            8'd111: s = 14'd7681; 8'd112: s = 14'd7773; 8'd113: s = 14'd7867;
            8'd114: s = 14'd7962; 8'd115: s = 14'd8056; 8'd116: s = 14'd8137;
            8'd117: s = 14'd8229; 8'd118: s = 14'd8313; 8'd119: s = 14'd8395;
            8'd120: s = 14'd8463; 8'd121: s = 14'd8558; 8'd122: s = 14'd8616;
            8'd123: s = 14'd8698; 8'd124: s = 14'd8792; 8'd125: s = 14'd8861;
            8'd126: s = 14'd8955; 8'd127: s = 14'd9027; 8'd128: s = 14'd9085;
            8'd129: s = 14'd9177; 8'd130: s = 14'd9235; 8'd131: s = 14'd9330;
            8'd132: s = 14'd9424; 8'd133: s = 14'd9519; 8'd134: s = 14'd9600;
            8'd135: s = 14'd9636; 8'd136: s = 14'd9694; 8'd137: s = 14'd9752;
            8'd138: s = 14'd9810; 8'd139: s = 14'd9904; 8'd140: s = 14'd9997;
            8'd141: s = 14'd10044;
            default: s = 14'd10044;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/csbd_front.sv =====
// ----------------------------------------------------------------------------
// csbd_front
// walks each cell voltage up the rom and queues a classified lookup job
// ----------------------------------------------------------------------------
`default_nettype none
module csbd_front import csbd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_go,
    input  wire t_volt [NUM_CELLS-1:0] i_volts,
    input  wire logic                i_q_full,
    output logic                     o_push,
    output t_job                     o_job,
    output logic                     o_busy
);

    t_fe_state r_state, n_state;
    t_volt [NUM_CELLS-1:0] r_volts;
    t_cell r_cell, n_cell;
    t_idx  r_idx, n_idx;
    logic  r_clamp, n_clamp;

    t_volt w_v;
    t_volt w_rv;

    assign w_v  = r_volts[r_cell];
    assign w_rv = rom_volt(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cell  <= n_cell;
        r_idx   <= n_idx;
        r_clamp <= n_clamp;
        if (i_go) begin
            r_volts <= i_volts;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cell  = r_cell;
        n_idx   = r_idx;
        n_clamp = r_clamp;
        o_push  = 1'b0;
        case (r_state)
            FE_IDLE: begin
                if (i_go) begin
                    n_state = FE_SEARCH;
                    n_cell  = '0;
                    n_idx   = '0;
                end
            end
            FE_SEARCH: begin
                // first point with voltage at or above the cell voltage
                if (w_v <= w_rv) begin
                    n_clamp = (w_v == w_rv);
                    n_state = FE_PUSH;
                end else if (r_idx == IDX_W'(TABLE_POINTS - 1)) begin
                    n_clamp = 1'b1;
                    n_state = FE_PUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            FE_PUSH: begin
                if (!i_q_full) begin
                    o_push = 1'b1;
                    n_idx  = '0;
                    if (r_cell == CELL_W'(NUM_CELLS - 1)) begin
                        n_state = FE_IDLE;
                    end else begin
                        n_cell  = r_cell + 1'b1;
                        n_state = FE_SEARCH;
                    end
                end
            end
            default: n_state = FE_IDLE;
        endcase
    end

    assign o_job  = '{clamp: r_clamp, idx: r_idx, volt: w_v, cell_no: r_cell};
    assign o_busy = (r_state != FE_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/csbd_queue.sv =====
// ----------------------------------------------------------------------------
// csbd_queue
// two-entry job queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none
module csbd_queue import csbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_job
);

    t_job r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

endmodule
`default_nettype wire

// ===== rtl/core/csbd_back.sv =====
// ----------------------------------------------------------------------------
// csbd_back
// interpolates one queued job with a shared multiplier and restoring divider
// ----------------------------------------------------------------------------
`default_nettype none
module csbd_back import csbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_done,
    output t_cell     o_cell,
    output t_soc      o_soc,
    output logic      o_busy
);

    localparam int PROD_W = 31;
    localparam int CNT_W  = 5;

    t_be_state r_state, n_state;
    t_job  r_job;
    t_soc  r_sl;
    logic [SOC_W-1:0]  r_rise;
    logic [VOLT_W-1:0] r_dv, r_run;
    logic [PROD_W-1:0] r_q;     // dividend shifting out, quotient shifting in
    logic [VOLT_W:0]   r_rem;
    logic [CNT_W-1:0]  r_cnt;
    t_soc  r_soc;

    t_idx  w_lo;
    t_soc  w_sh, w_sl;
    t_volt w_vh, w_vl;
    logic [VOLT_W:0] w_trial;
    logic [VOLT_W:0] w_sub;

    assign w_lo  = i_job.idx - 1'b1;
    assign w_sh  = rom_soc(i_job.idx);
    assign w_sl  = rom_soc(w_lo);
    assign w_vh  = rom_volt(i_job.idx);
    assign w_vl  = rom_volt(w_lo);
    assign w_trial = {r_rem[VOLT_W-1:0], r_q[PROD_W-1]};
    assign w_sub   = w_trial - {1'b0, r_run};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BE_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            BE_IDLE: begin
                if (!i_empty) begin
                    r_job  <= i_job;
                    r_sl   <= w_sl;
                    r_soc  <= w_sh;
                    r_rise <= (w_sh >= w_sl) ? (w_sh - w_sl) : '0;
                    r_dv   <= i_job.volt - w_vl;
                    r_run  <= w_vh - w_vl;
                end
            end
            BE_MUL: begin
                r_q   <= PROD_W'(r_rise) * PROD_W'(r_dv);
                r_rem <= '0;
                r_cnt <= '0;
            end
            BE_DIV: begin
                if (!w_sub[VOLT_W]) begin
                    r_rem <= w_sub;
                    r_q   <= {r_q[PROD_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[PROD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    r_soc <= r_sl + SOC_W'(r_run == '0 ? '0
                             : {r_q[PROD_W-2:0], !w_sub[VOLT_W]});
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            BE_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    // rom soc directly for exact hits and out-of-range voltages
                    n_state = (i_job.clamp || i_job.idx == '0) ? BE_DONE : BE_MUL;
                end
            end
            BE_MUL:  n_state = BE_DIV;
            BE_DIV:  if (r_cnt == CNT_W'(PROD_W - 1)) n_state = BE_DONE;
            BE_DONE: begin
                o_done  = 1'b1;
                n_state = BE_IDLE;
            end
            default: n_state = BE_IDLE;
        endcase
    end

    assign o_cell = r_job.cell_no;
    assign o_soc  = r_soc;
    assign o_busy = (r_state != BE_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/cell_soc_balance_decision_unit.sv =====
// ----------------------------------------------------------------------------
// cell_soc_balance_decision_unit
// four-cell voltage to state-of-charge lookup and discharge decision
// ----------------------------------------------------------------------------
// One item (four cell voltages) is taken when start is high and busy low.
// A front end walks the 142-point rom, one point a cycle, per cell and
// queues a job; a back end does a multiply and a 31-step restoring divide
// per interpolated cell, while exact hits and clamped voltages skip both.
// The rom walk and the divides set the time: the result strobe comes soonest
// after the accepting edge when every cell sits at or below the first point,
// and latest when every cell falls between the last two points.
// busy drops as the strobe appears, so the next item can be taken at the
// edge that ends the strobe cycle. The result appears on the o_ ports for
// exactly one cycle with o_valid high and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none
module cell_soc_balance_decision_unit import csbd_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [15:0]   i_cell1_voltage,
    input  wire logic [15:0]   i_cell2_voltage,
    input  wire logic [15:0]   i_cell3_voltage,
    input  wire logic [15:0]   i_cell4_voltage,
    output logic               o_valid,
    output logic [13:0]        o_cell1_soc,
    output logic [13:0]        o_cell2_soc,
    output logic [13:0]        o_cell3_soc,
    output logic [13:0]        o_cell4_soc,
    output logic [13:0]        o_lowest_soc,
    output logic               o_discharge_cell1,
    output logic               o_discharge_cell2,
    output logic               o_discharge_cell3,
    output logic               o_discharge_cell4
);

    logic r_busy;
    logic w_go;
    t_volt [NUM_CELLS-1:0] w_volts;
    logic w_push, w_pop, w_full, w_empty, w_fe_busy, w_be_busy, w_done;
    t_job w_job_in, w_job_out;
    t_cell w_cell;
    t_soc  w_soc;

    t_soc [NUM_CELLS-1:0] r_soc;
    t_soc r_low;
    logic r_valid;
    logic r_pend;   // all cells collected, min/flags next cycle

    assign w_go    = start && !r_busy;
    assign w_volts = {i_cell4_voltage, i_cell3_voltage, i_cell2_voltage, i_cell1_voltage};

    csbd_front u_front (
        .i_clk, .i_rst_n, .i_go(w_go), .i_volts(w_volts), .i_q_full(w_full),
        .o_push(w_push), .o_job(w_job_in), .o_busy(w_fe_busy)
    );

    csbd_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_job_in), .i_pop(w_pop),
        .o_full(w_full), .o_empty(w_empty), .o_job(w_job_out)
    );

    csbd_back u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_job(w_job_out), .o_pop(w_pop),
        .o_done(w_done), .o_cell(w_cell), .o_soc(w_soc), .o_busy(w_be_busy)
    );

    // minimum over the four collected socs, registered with the result
    t_soc w_min01, w_min23, w_min;
    assign w_min01 = (r_soc[1] < r_soc[0]) ? r_soc[1] : r_soc[0];
    assign w_min23 = (r_soc[3] < r_soc[2]) ? r_soc[3] : r_soc[2];
    assign w_min   = (w_min23 < w_min01) ? w_min23 : w_min01;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= r_pend;
            r_pend  <= w_done && (w_cell == CELL_W'(NUM_CELLS - 1));
            if (w_go) begin
                r_busy <= 1'b1;
            end else if (r_pend) begin
                r_busy <= 1'b0;
            end
        end
        if (w_done) begin
            r_soc[w_cell] <= w_soc;
        end
        if (r_pend) begin
            r_low <= w_min;
        end
    end

    assign busy              = r_busy;
    assign o_valid           = r_valid;
    assign o_cell1_soc       = r_soc[0];
    assign o_cell2_soc       = r_soc[1];
    assign o_cell3_soc       = r_soc[2];
    assign o_cell4_soc       = r_soc[3];
    assign o_lowest_soc      = r_low;
    assign o_discharge_cell1 = r_soc[0] > r_low;
    assign o_discharge_cell2 = r_soc[1] > r_low;
    assign o_discharge_cell3 = r_soc[2] > r_low;
    assign o_discharge_cell4 = r_soc[3] > r_low;

    // no item may start while the pipeline still holds work
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |-> !w_fe_busy && !w_be_busy && w_empty) else $error("start while busy");
    // queue never overflows or underflows
    a_q_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("queue overflow");
    a_q_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("queue underflow");
    // result strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");

endmodule
`default_nettype wire
